>>> src/itcf_pkg.sv
// Shared types, constants and the check byte function for the torque command framer.
`timescale 1ns / 1ps
`default_nettype none

package itcf_pkg;

    localparam int THROTTLE_W = 11;
    localparam int SPEED_W    = 15;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int MAG_W      = 16;
    localparam int NUM_W      = 32;
    localparam int SEQ_W      = 3;
    localparam int DIV_CNT_W  = 4;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER_LOWER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSPEED   = 2'd3;

    localparam logic [MAG_W-1:0] TORQUE_OFFSET  = 16'd32128;
    localparam logic [CFG_W-1:0] THROTTLE_SCALE = 15'd1000;

    // divide by the throttle scale as a reciprocal multiply; exact for every
    // scale product up to 1024 * 32767
    localparam int SCALE_PROD_W = 26;
    localparam int RECIP_W      = 26;
    localparam int SCALE_SHIFT  = 35;
    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'(((64'd1 << SCALE_SHIFT) + 64'(THROTTLE_SCALE) - 64'd1) / 64'(THROTTLE_SCALE));

    localparam logic [7:0] CMD_ENABLE  = 8'h80;
    localparam logic [7:0] CMD_DISABLE = 8'h40;
    localparam logic [7:0] CMD_FORWARD = 8'h20;
    localparam logic [7:0] CMD_REVERSE = 8'h10;
    localparam logic [7:0] CHK_MASK_A  = 8'hA0;
    localparam logic [7:0] CHK_MASK_B  = 8'h60;
    localparam logic [7:0] CHK_SEED    = 8'h7F;

    localparam logic [7:0] CHECK_TABLE [16] = '{
        8'hAA, 8'h7F, 8'hFE, 8'h29, 8'h52, 8'hA4, 8'h9D, 8'hEF,
        8'h0B, 8'h16, 8'h2C, 8'h58, 8'hB0, 8'h60, 8'hC0, 8'h01
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the request and advance the sequence
        logic mul_scale;  // throttle magnitude times max torque
        logic take_recip; // latch the scaled product over 1000 as torque magnitude
        logic mul_taper;  // torque magnitude times distance into the taper
        logic div_start;  // load the divider with the taper span
        logic take_quot;  // latch the quotient as torque magnitude
        logic finish;     // build the result into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_last;   // divider is on its final step
        logic taper_mul;  // regen request inside the taper band
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

    function automatic logic [7:0] check_byte(input logic [7:0] cmd, input logic [15:0] word);
        logic [15:0] t;
        logic [7:0]  acc;
        t   = word;
        acc = CHK_SEED;
        if ((cmd & CHK_MASK_A) == CHK_MASK_A || (cmd & CHK_MASK_B) == CHK_MASK_B) begin
            t = t + 16'd1;
        end
        if (t[1:0] == 2'b11) begin
            t = t + 16'd4;
        end
        for (int i = 0; i < 16; i++) begin
            if (t[i]) begin
                acc = acc ^ CHECK_TABLE[i];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> src/itcf_ctrl.sv
// Sequencing state machine for the torque command framer.
`timescale 1ns / 1ps
`default_nettype none

module itcf_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  itcf_pkg::t_dp_status i_status,
    output itcf_pkg::t_dp_cmd    o_cmd
);
    import itcf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_RECIP,
        ST_CHK,
        ST_MUL2,
        ST_DIV2_GO,
        ST_DIV2_RUN,
        ST_TAKE2,
        ST_FIN
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_ready <= 1'b1;
                    if (i_s_axis_tvalid && r_ready) begin
                        r_state <= ST_MUL1;
                        r_ready <= 1'b0;
                    end
                end
                ST_MUL1:     r_state <= ST_RECIP;
                ST_RECIP:    r_state <= ST_CHK;
                ST_CHK:      r_state <= i_status.taper_mul ? ST_MUL2 : ST_FIN;
                ST_MUL2:     r_state <= ST_DIV2_GO;
                ST_DIV2_GO:  r_state <= ST_DIV2_RUN;
                ST_DIV2_RUN: if (i_status.div_last) r_state <= ST_TAKE2;
                ST_TAKE2:    r_state <= ST_FIN;
                ST_FIN: begin
                    // hold until the output register drains
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default:     r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == ST_IDLE) && r_ready && i_s_axis_tvalid;
        o_cmd.mul_scale  = (r_state == ST_MUL1);
        o_cmd.take_recip = (r_state == ST_RECIP);
        o_cmd.mul_taper  = (r_state == ST_MUL2);
        o_cmd.div_start  = (r_state == ST_DIV2_GO);
        o_cmd.take_quot  = (r_state == ST_TAKE2);
        o_cmd.finish     = (r_state == ST_FIN) && i_status.out_free;
    end

endmodule

`default_nettype wire

>>> src/itcf_datapath.sv
// Configuration registers, multipliers, divider and output register of the framer.
`timescale 1ns / 1ps
`default_nettype none

module itcf_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [itcf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [itcf_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire  [itcf_pkg::THROTTLE_W-1:0]      i_throttle,
    input  wire  [itcf_pkg::SPEED_W-1:0]         i_motor_speed,
    input  wire                                  i_drive_enabled,
    input  wire                                  i_forward_gear,
    input  itcf_pkg::t_dp_cmd                    i_cmd,
    output itcf_pkg::t_dp_status                 o_status,
    input  wire                                  i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [7:0]                           o_command_byte,
    output logic [itcf_pkg::MAG_W-1:0]           o_torque_word,
    output logic [7:0]                           o_check_byte
);
    import itcf_pkg::*;

    logic [CFG_W-1:0]      r_max_torque;
    logic [CFG_W-1:0]      r_taper_upper;
    logic [CFG_W-1:0]      r_taper_lower;
    logic [CFG_W-1:0]      r_overspeed;

    logic [SEQ_W-1:0]      r_seq;
    logic [7:0]            r_cmd_byte;
    logic                  r_thr_neg;
    logic [THROTTLE_W-1:0] r_thr_mag;
    logic [SPEED_W-1:0]    r_speed;
    logic [MAG_W-1:0]      r_mag;
    logic [NUM_W-1:0]      r_num;

    logic [NUM_W-1:0]      r_div_q;
    logic [CFG_W-1:0]      r_div_rem;
    logic [CFG_W-1:0]      r_div_d;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic                  r_div_busy;

    logic                  r_out_valid;
    logic [7:0]            r_out_cmd;
    logic [MAG_W-1:0]      r_out_word;
    logic [7:0]            r_out_check;

    logic [SEQ_W-1:0]      n_seq;
    logic [THROTTLE_W-1:0] w_thr_mag;
    logic [25:0]           w_prod_scale;
    logic [SCALE_PROD_W+RECIP_W-1:0] w_prod_recip;
    logic [30:0]           w_prod_taper;
    logic [SPEED_W-1:0]    w_into;
    logic [CFG_W-1:0]      w_span;
    logic                  w_neg;
    logic                  w_below_upper;
    logic                  w_below_lower;
    logic                  w_taper_zero;
    logic                  w_overspeed;
    logic [MAG_W-1:0]      w_fin_mag;
    logic [MAG_W-1:0]      w_word;
    logic [CFG_W:0]        w_rem_a;
    logic [CFG_W:0]        w_rem_a2;
    logic [CFG_W:0]        w_rem_b;
    logic [CFG_W:0]        w_rem_b2;
    logic                  w_bit_a;
    logic                  w_bit_b;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_torque  <= '0;
            r_taper_upper <= '0;
            r_taper_lower <= '0;
            r_overspeed   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_TORQUE:  r_max_torque  <= i_cfg_data;
                REG_TAPER_UPPER: r_taper_upper <= i_cfg_data;
                REG_TAPER_LOWER: r_taper_lower <= i_cfg_data;
                REG_OVERSPEED:   r_overspeed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_seq        = r_seq + SEQ_W'(1);
    assign w_thr_mag    = i_throttle[THROTTLE_W-1] ? (~i_throttle + THROTTLE_W'(1)) : i_throttle;
    assign w_prod_scale = 26'(r_thr_mag) * 26'(r_max_torque);
    assign w_prod_recip = (SCALE_PROD_W+RECIP_W)'(r_num[SCALE_PROD_W-1:0])
                        * (SCALE_PROD_W+RECIP_W)'(SCALE_RECIP);
    assign w_into       = r_speed - r_taper_lower;
    assign w_span       = r_taper_upper - r_taper_lower;
    assign w_prod_taper = 31'(r_mag) * 31'(w_into);

    assign w_neg         = r_thr_neg && (r_mag != '0);
    assign w_below_upper = r_speed < r_taper_upper;
    assign w_below_lower = r_speed < r_taper_lower;
    assign w_taper_zero  = w_neg && w_below_upper && w_below_lower;
    assign w_overspeed   = r_speed > r_overspeed;

    // radix-4 restoring divide step
    always_comb begin
        w_rem_a  = {r_div_rem, r_div_q[NUM_W-1]};
        w_bit_a  = w_rem_a >= {1'b0, r_div_d};
        w_rem_a2 = w_bit_a ? (w_rem_a - {1'b0, r_div_d}) : w_rem_a;
        w_rem_b  = {w_rem_a2[CFG_W-1:0], r_div_q[NUM_W-2]};
        w_bit_b  = w_rem_b >= {1'b0, r_div_d};
        w_rem_b2 = w_bit_b ? (w_rem_b - {1'b0, r_div_d}) : w_rem_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (r_div_cnt == '1) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_q   <= r_num;
            r_div_rem <= '0;
            r_div_d   <= w_span;
        end else if (r_div_busy) begin
            r_div_q   <= {r_div_q[NUM_W-3:0], w_bit_a, w_bit_b};
            r_div_rem <= w_rem_b2[CFG_W-1:0];
        end
    end

    // request capture and torque path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (i_cmd.load) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_byte <= (i_drive_enabled ? CMD_ENABLE : CMD_DISABLE)
                        | (i_forward_gear ? CMD_FORWARD : CMD_REVERSE)
                        | {5'd0, n_seq};
            r_thr_neg  <= i_throttle[THROTTLE_W-1];
            r_thr_mag  <= w_thr_mag;
            r_speed    <= i_motor_speed;
        end
        if (i_cmd.mul_scale) begin
            r_num <= NUM_W'(w_prod_scale);
        end else if (i_cmd.mul_taper) begin
            r_num <= NUM_W'(w_prod_taper);
        end
        if (i_cmd.take_recip) begin
            r_mag <= w_prod_recip[SCALE_SHIFT +: MAG_W];
        end else if (i_cmd.take_quot) begin
            r_mag <= r_div_q[MAG_W-1:0];
        end
    end

    always_comb begin
        w_fin_mag = w_taper_zero ? '0 : r_mag;
        if (w_overspeed) begin
            w_fin_mag = w_fin_mag >> 1;
        end
        w_word = r_thr_neg ? (TORQUE_OFFSET - w_fin_mag) : (TORQUE_OFFSET + w_fin_mag);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_cmd   <= r_cmd_byte;
            r_out_word  <= w_word;
            r_out_check <= check_byte(r_cmd_byte, w_word);
        end
    end

    assign o_status.div_last  = r_div_busy && (r_div_cnt == '1);
    assign o_status.taper_mul = w_neg && w_below_upper && !w_below_lower;
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid     = r_out_valid;
    assign o_command_byte = r_out_cmd;
    assign o_torque_word  = r_out_word;
    assign o_check_byte   = r_out_check;

`ifndef SYNTHESIS
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !i_cmd.div_start)
        else $error("divider restarted while busy");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("result not registered after finish");

    a_finish_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_m_tready))
        else $error("pending result overwritten");

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_seq == $past(r_seq) + SEQ_W'(1)))
        else $error("sequence did not advance by one");
`endif

endmodule

`default_nettype wire

>>> src/inverter_torque_command_framer.sv
// Top level of the inverter torque command framer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one throttle/speed request and returns one command frame: command
// byte, torque word (torque plus 32128) and check byte. A request passes
// through the scale product, a reciprocal multiply for the divide by 1000,
// the taper check and the final assembly to a registered result. A regen
// request inside the taper band adds a second product and the radix-4
// divider, which runs 16 steps for the taper ratio. The next request is
// accepted the cycle after the result is registered, so no request is
// taken while one is in progress. A result waits in the output register
// while the next request is accepted and computed; if it is still waiting
// when the next one is done, the framer holds in its last step.
// Configuration writes take effect at once and must be made while no
// request is in flight.
module inverter_torque_command_framer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [itcf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [itcf_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // throttle[10:0], motor_speed[25:11], drive_enabled[26], forward_gear[27], zero[31:28]
    input  wire  [itcf_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // command_byte[7:0], torque_word[23:8], check_byte[31:24]
    output logic [itcf_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata
);
    import itcf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [7:0]       w_command_byte;
    logic [MAG_W-1:0] w_torque_word;
    logic [7:0]       w_check_byte;

    itcf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    itcf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_throttle      (i_s_axis_tdata[10:0]),
        .i_motor_speed   (i_s_axis_tdata[25:11]),
        .i_drive_enabled (i_s_axis_tdata[26]),
        .i_forward_gear  (i_s_axis_tdata[27]),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_m_tready      (i_m_axis_tready),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_command_byte  (w_command_byte),
        .o_torque_word   (w_torque_word),
        .o_check_byte    (w_check_byte)
    );

    assign o_m_axis_tdata = {w_check_byte, w_torque_word, w_command_byte};

endmodule

`default_nettype wire

>>> tb/itcf_checker.sv
// Checker for the torque command framer: predicts each frame and compares it with the output.
`timescale 1ns / 1ps

module itcf_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [itcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [itcf_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                 i_req_valid,
    input  wire                                 i_req_ready,
    // throttle[10:0], motor_speed[25:11], drive_enabled[26], forward_gear[27], zero[31:28]
    input  wire  [itcf_pkg::IN_DATA_W-1:0]      i_req_data,
    input  wire                                 i_frame_valid,
    input  wire                                 i_frame_ready,
    // command_byte[7:0], torque_word[23:8], check_byte[31:24]
    input  wire  [itcf_pkg::OUT_DATA_W-1:0]     i_frame_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam logic [7:0]  CMD_ENABLED  = 8'h80;
    localparam logic [7:0]  CMD_DISABLED = 8'h40;
    localparam logic [7:0]  CMD_FWD      = 8'h20;
    localparam logic [7:0]  CMD_REV      = 8'h10;
    localparam logic [7:0]  GUARD_MASK_A = 8'hA0;
    localparam logic [7:0]  GUARD_MASK_B = 8'h60;
    localparam logic [7:0]  GUARD_SEED   = 8'h7F;
    localparam longint      TORQUE_BIAS  = 32128;
    localparam longint      PER_MILLE    = 1000;
    localparam int          REPORT_MAX   = 10;

    localparam logic [7:0] GUARD_TABLE [16] = '{
        8'hAA, 8'h7F, 8'hFE, 8'h29, 8'h52, 8'hA4, 8'h9D, 8'hEF,
        8'h0B, 8'h16, 8'h2C, 8'h58, 8'hB0, 8'h60, 8'hC0, 8'h01
    };

    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] word;
        logic [7:0]  chk;
    } t_frame;

    logic [14:0] max_torque_q;
    logic [14:0] taper_upper_q;
    logic [14:0] taper_lower_q;
    logic [14:0] overspeed_q;
    logic [2:0]  seq_q;
    t_frame      expected_frames [$];
    int          fail_count;

    assign o_fail_count = fail_count;

    function automatic logic [7:0] guard_byte(input logic [7:0] cmd, input logic [15:0] word);
        logic [15:0] t;
        logic [7:0]  acc;
        t   = word;
        acc = GUARD_SEED;
        if ((cmd & GUARD_MASK_A) == GUARD_MASK_A || (cmd & GUARD_MASK_B) == GUARD_MASK_B) begin
            t = t + 16'd1;
        end
        if (t[1:0] == 2'b11) begin
            t = t + 16'd4;
        end
        for (int i = 0; i < 16; i++) begin
            if (t[i]) begin
                acc = acc ^ GUARD_TABLE[i];
            end
        end
        return acc;
    endfunction

    // Frame for one request, with the sequence number it is to carry.
    function automatic t_frame frame_for_request(input logic [31:0] data, input logic [2:0] seq);
        longint thr;
        longint spd;
        longint torque;
        longint upper;
        longint lower;
        t_frame f;
        thr   = longint'($signed(data[10:0]));
        spd   = longint'({1'b0, data[25:11]});
        upper = longint'({1'b0, taper_upper_q});
        lower = longint'({1'b0, taper_lower_q});
        f.cmd = (data[26] ? CMD_ENABLED : CMD_DISABLED) | (data[27] ? CMD_FWD : CMD_REV)
                | {5'b0, seq};
        torque = (thr * longint'({1'b0, max_torque_q})) / PER_MILLE;
        // taper regen at low speed, nothing below the lower edge
        if (torque < 0 && spd < upper) begin
            if (spd < lower) begin
                torque = 0;
            end else begin
                torque = (torque * (spd - lower)) / (upper - lower);
            end
        end
        if (spd > longint'({1'b0, overspeed_q})) begin
            torque = torque / 2;
        end
        f.word = 16'(torque + TORQUE_BIAS);
        f.chk  = guard_byte(f.cmd, f.word);
        return f;
    endfunction

    task automatic note_failure(input string what, input t_frame want, input t_frame got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t: %s: expected cmd %02h word %04h chk %02h, got cmd %02h word %04h chk %02h",
                     $time, what, want.cmd, want.word, want.chk, got.cmd, got.word, got.chk);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            max_torque_q  <= '0;
            taper_upper_q <= '0;
            taper_lower_q <= '0;
            overspeed_q   <= '0;
            seq_q         <= '0;
            expected_frames.delete();
            fail_count = 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    itcf_pkg::REG_MAX_TORQUE:  max_torque_q  <= i_cfg_data;
                    itcf_pkg::REG_TAPER_UPPER: taper_upper_q <= i_cfg_data;
                    itcf_pkg::REG_TAPER_LOWER: taper_lower_q <= i_cfg_data;
                    itcf_pkg::REG_OVERSPEED:   overspeed_q   <= i_cfg_data;
                    default: ;
                endcase
            end
            // sequence advances before it goes into the frame
            if (i_req_valid && i_req_ready) begin
                expected_frames.push_back(frame_for_request(i_req_data, seq_q + 3'd1));
                seq_q <= seq_q + 3'd1;
            end
            if (i_frame_valid && i_frame_ready) begin
                got.cmd  = i_frame_data[7:0];
                got.word = i_frame_data[23:8];
                got.chk  = i_frame_data[31:24];
                if (expected_frames.size() == 0) begin
                    note_failure("frame with no request pending", '0, got);
                end else begin
                    want = expected_frames.pop_front();
                    if (got.cmd != want.cmd || got.word != want.word || got.chk != want.chk) begin
                        note_failure("frame mismatch", want, got);
                    end
                end
            end
            o_pending <= expected_frames.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the torque command framer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int ITEMS_PER_PHASE = 330;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 60;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [itcf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [itcf_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                 req_valid = 1'b0;
    logic [itcf_pkg::IN_DATA_W-1:0]       req_data = '0;
    logic                                 frame_ready = 1'b0;
    logic                                 req_ready;
    logic                                 frame_valid;
    logic [itcf_pkg::OUT_DATA_W-1:0]      frame_data;
    int                                   fail_count;
    int                                   pending;
    int                                   send_idle_pct = 9;
    int                                   recv_idle_pct = 86;
    int                                   quiet_cycles = 0;
    int                                   cur_upper = 0;
    int                                   cur_lower = 0;
    int                                   cur_overspeed = 0;

    inverter_torque_command_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (frame_valid),
        .i_m_axis_tready (frame_ready),
        .o_m_axis_tdata  (frame_data)
    );

    itcf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_frame_valid (frame_valid),
        .i_frame_ready (frame_ready),
        .i_frame_data  (frame_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_ready <= 1'b0;
        end else begin
            frame_ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (req_valid && req_ready) || (frame_valid && frame_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("inverter_torque_command_framer verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pack_request(input int thr, input int spd,
                                                 input bit en, input bit fwd);
        return {4'b0, fwd, en, 15'(spd), 11'(thr)};
    endfunction

    function automatic int clamp_speed(input int spd);
        if (spd < 0) begin
            return 0;
        end
        return (spd > 32767) ? 32767 : spd;
    endfunction

    // Aim speeds at the taper band and the overspeed edge more often than not.
    function automatic logic [31:0] random_request();
        int thr;
        int spd;
        int lo;
        int hi;
        lo = (cur_lower < cur_upper) ? cur_lower : cur_upper;
        hi = (cur_lower < cur_upper) ? cur_upper : cur_lower;
        case ($urandom_range(0, 9))
            0, 1, 2: spd = int'($urandom_range(0, 32767));
            3, 4, 5: spd = int'($urandom_range(lo, hi));
            6:       spd = clamp_speed(cur_lower + int'($urandom_range(0, 4)) - 2);
            7:       spd = clamp_speed(cur_upper + int'($urandom_range(0, 4)) - 2);
            default: spd = clamp_speed(cur_overspeed + int'($urandom_range(0, 4)) - 2);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: thr = -int'($urandom_range(0, 1000));
            4, 5, 6:    thr = int'($urandom_range(0, 2000)) - 1000;
            7:          thr = int'($urandom_range(0, 4)) * 500 - 1000;
            8:          thr = int'($urandom_range(0, 6)) - 3;
            default:    thr = int'($signed(11'($urandom)));
        endcase
        return pack_request(thr, spd, 1'($urandom), 1'($urandom));
    endfunction

    task automatic send_request(input logic [31:0] data);
        if (int'($urandom_range(0, 99)) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(0, 99)) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= data;
        // sample ready away from the edge, then take the request on the edge
        do @(negedge i_clk); while (!req_ready);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_settings(input int max_torque, input int upper,
                                  input int lower, input int overspeed);
        req_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= itcf_pkg::REG_MAX_TORQUE;
        cfg_data  <= 15'(max_torque);
        @(posedge i_clk);
        cfg_index <= itcf_pkg::REG_TAPER_UPPER;
        cfg_data  <= 15'(upper);
        @(posedge i_clk);
        cfg_index <= itcf_pkg::REG_TAPER_LOWER;
        cfg_data  <= 15'(lower);
        @(posedge i_clk);
        cfg_index <= itcf_pkg::REG_OVERSPEED;
        cfg_data  <= 15'(overspeed);
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        cur_upper     = upper;
        cur_lower     = lower;
        cur_overspeed = overspeed;
    endtask

    initial begin
        int upper;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no torque at all, any speed above zero is overspeed
        send_request(pack_request(1000, 0, 1'b1, 1'b1));
        send_request(pack_request(-1000, 32767, 1'b0, 1'b0));

        write_settings(30000, 20000, 5000, 25000);
        send_request(pack_request(1000, 0, 1'b1, 1'b1));
        send_request(pack_request(-1000, 0, 1'b1, 1'b0));
        send_request(pack_request(-1000, 4999, 1'b0, 1'b1));
        send_request(pack_request(-1000, 5000, 1'b0, 1'b0));
        send_request(pack_request(-1000, 5001, 1'b1, 1'b1));
        send_request(pack_request(-1000, 12500, 1'b1, 1'b0));
        send_request(pack_request(-1000, 19999, 1'b0, 1'b1));
        send_request(pack_request(-1000, 20000, 1'b0, 1'b0));
        send_request(pack_request(-1000, 25000, 1'b1, 1'b1));
        send_request(pack_request(-1000, 25001, 1'b1, 1'b0));
        send_request(pack_request(1000, 32767, 1'b0, 1'b1));
        send_request(pack_request(0, 32767, 1'b1, 1'b1));
        send_request(pack_request(-1, 10000, 1'b1, 1'b1));
        send_request(pack_request(1, 10000, 1'b0, 1'b1));
        send_request(pack_request(-1024, 30000, 1'b1, 1'b0));
        send_request(pack_request(1023, 100, 1'b0, 1'b0));
        send_request(pack_request(-7, 6000, 1'b1, 1'b1));
        send_request(pack_request(333, 25001, 1'b0, 1'b1));

        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0: write_settings(30000, 20000, 5000, 25000);
                1: write_settings(0, 0, 0, 0);
                2: write_settings(30000, 32767, 0, 32767);
                3: write_settings(1, 1, 0, 0);
                4: begin
                    upper = int'($urandom_range(1, 32767));
                    write_settings(int'($urandom_range(0, 30000)), upper,
                                   int'($urandom_range(0, upper - 1)),
                                   int'($urandom_range(0, 32767)));
                end
                default: write_settings(12345, 3000, 3001, 16000);
            endcase
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("inverter_torque_command_framer verification clean");
        end else begin
            $display("inverter_torque_command_framer verification failed");
        end
        $finish;
    end

endmodule
